// ===== hw/rtl/periodic_alarm_table_top_macros.svh =====
// ----------------------------------------------------------------------------
// Alarm table assertion macros
// Concurrent assertion templates used by the alarm table top module.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_ALARM_TABLE_TOP_MACROS_SVH
`define PERIODIC_ALARM_TABLE_TOP_MACROS_SVH
// Checks that an implication holds on every clock edge out of reset.
`define PAT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Checks that a condition holds in the cycle after another holds.
`define PAT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// Alarm table package
// Shared constants and types of the periodic alarm table.
// ----------------------------------------------------------------------------
`default_nettype none
package pat_pkg;
    localparam int NUM_ALARMS_DEF   = 8;
    localparam int ALARM_PERIOD_DEF = 5;
    localparam int DECREMENT        = 5;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LOW     = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOTFND  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE, FSM_MOD, FSM_SCAN, FSM_OUT, FSM_REPLY
    } fsm_t;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    // Command broadcast to every slot cell of the chain.
    typedef struct packed {
        logic        tick;     // period boundary decrement
        logic        add;
        logic        remove;
        logic        query;
        logic [5:0]  id;       // target id of remove/query
        logic [30:0] start;
        logic        rearm;
    } cell_cmd_t;

    // Report returned by one slot cell.
    typedef struct packed {
        logic        valid;
        logic        fire;
        logic [30:0] reload;
        logic [31:0] remaining;
    } cell_rpt_t;
endpackage
`default_nettype wire

// ===== hw/rtl/pat_if.sv =====
// ----------------------------------------------------------------------------
// Alarm table channels
// Valid/ready channel interfaces for input and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface pat_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [30:0] start_ticks;
    logic        rearm;
    logic [2:0]  target_id;
    modport source (output valid, action, start_ticks, rearm, target_id, input ready);
    modport sink (input valid, action, start_ticks, rearm, target_id, output ready);
endinterface

interface pat_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  result_id;
    logic signed [31:0] remaining;
    logic        fired;
    logic [30:0] reload_ticks;
    logic [63:0] tick_now;
    logic        preempt_due;
    logic        last;
    modport source (output valid, status, result_id, remaining, fired, reload_ticks,
                    tick_now, preempt_due, last, input ready);
    modport sink (input valid, status, result_id, remaining, fired, reload_ticks,
                  tick_now, preempt_due, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pat_cell.sv =====
// ----------------------------------------------------------------------------
// Alarm slot cell
// Holds one alarm slot and applies the command it receives.
// ----------------------------------------------------------------------------
`default_nettype none
module pat_cell #(
    parameter int IDX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_en,
    input  pat_pkg::cell_cmd_t   cmd,
    input  wire logic            add_here,
    output pat_pkg::cell_rpt_t   rpt
);
    import pat_pkg::*;

    logic        valid_reg, valid_next;
    logic signed [31:0] rem_reg, rem_next;
    logic [30:0] reload_reg;
    logic        rearm_reg;
    logic signed [31:0] dec;
    logic        hit;

    // Decrement for the period boundary.
    assign dec = (rem_reg > 0) ? rem_reg - 32'(DECREMENT) : rem_reg;
    assign hit = (cmd.id == 6'(IDX));

    // Next state of the slot.
    always_comb
    begin
        valid_next = valid_reg;
        rem_next   = rem_reg;
        if (cmd_en && cmd.tick && valid_reg)
        begin
            rem_next = dec;
            if (dec <= 0 && rearm_reg)
                rem_next = {1'b0, reload_reg};
        end
        else if (cmd_en && cmd.add && add_here)
        begin
            valid_next = 1'b1;
            rem_next   = {1'b0, cmd.start};
        end
        else if (cmd_en && cmd.remove && hit)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (cmd_en && cmd.add && add_here)
        begin
            reload_reg <= cmd.start;
            rearm_reg  <= cmd.rearm;
        end
    end

    // Report: fire flag is registered alongside the updated count.
    logic fire_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fire_reg <= 1'b0;
        else if (cmd_en)
            fire_reg <= cmd.tick && valid_reg && (dec <= 0);
    end

    assign rpt.valid     = valid_reg;
    assign rpt.fire      = fire_reg;
    assign rpt.reload    = reload_reg;
    assign rpt.remaining = rem_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/pat_chain.sv =====
// ----------------------------------------------------------------------------
// Alarm slot chain
// Row of slot cells with lowest-free-slot selection for add.
// ----------------------------------------------------------------------------
`default_nettype none
module pat_chain #(
    parameter int NUM_ALARMS = pat_pkg::NUM_ALARMS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_en,
    input  pat_pkg::cell_cmd_t   cmd,
    output pat_pkg::cell_rpt_t   rpt [NUM_ALARMS]
);
    import pat_pkg::*;

    // free_before[i]: some slot below i is free.
    logic [NUM_ALARMS:0] free_before;
    assign free_before[0] = 1'b0;

    for (genvar g = 0; g < NUM_ALARMS; g++)
    begin : g_cell
        assign free_before[g+1] = free_before[g] | ~rpt[g].valid;
        pat_cell #(.IDX(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd_en   (cmd_en),
            .cmd      (cmd),
            .add_here (~rpt[g].valid & ~free_before[g]),
            .rpt      (rpt[g])
        );
    end
endmodule
`default_nettype wire

// ===== hw/rtl/periodic_alarm_table_top.sv =====
// ----------------------------------------------------------------------------
// Periodic alarm table
// Timer tick driven alarm slots with add, remove and query by id.
// ----------------------------------------------------------------------------
// Usage: items enter on in_ch (valid/ready) and results leave on out_ch.
// A tick item yields one result per fired slot in id order, or a single
// result when none fires; every other item yields one result. The final
// result of an item carries last. Registers preempt_enable (address 0) and
// preempt_period (address 4) are written over the APB port while idle.
// A non-tick item passes through FSM_MOD and FSM_REPLY before its result
// is valid. A tick item first works out the bit-serial remainder of the
// tick count by preempt_period in FSM_MOD, then updates the slot cells,
// restarts the scan in FSM_SCAN and scans one slot per cycle in FSM_OUT
// while the result register is free. One item is in work at a time;
// ready is low while it is in work. A stalled receiver holds the result
// register and the scan. Reset clears the counters, the registers and
// all slot valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_alarm_table_top #(
    parameter int NUM_ALARMS   = pat_pkg::NUM_ALARMS_DEF,
    parameter int ALARM_PERIOD = pat_pkg::ALARM_PERIOD_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pat_in_if.sink           in_ch,
    pat_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pat_pkg::*;
`include "periodic_alarm_table_top_macros.svh"

    localparam int IW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int PW = (ALARM_PERIOD > 1) ? $clog2(ALARM_PERIOD) : 1;

    // Configuration registers.
    logic        en_reg;
    logic [31:0] per_reg;
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg  <= 1'b0;
            per_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_ENABLE)
            en_reg <= pwdata[0];
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_PERIOD)
            per_reg <= pwdata;
    end
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ENABLE)
            prdata = {31'b0, en_reg};
        else
            prdata = per_reg;
    end

    fsm_t state_reg, state_next;
    logic [63:0] tick_reg;
    logic [PW-1:0] phase_reg;
    logic [1:0]  act_reg;
    logic [30:0] start_reg;
    logic        rearm_reg;
    logic [2:0]  id_reg;
    logic        boundary_reg;
    logic [IW:0] scan_reg;
    logic        any_reg;
    logic [6:0]  mcnt_reg;
    logic [31:0] mrem_reg;
    logic [5:0]  bit_idx;
    logic [32:0] mrem_sh;
    logic [32:0] mrem_next;
    logic        div_step;
    logic        due;
    cell_rpt_t   rpt [NUM_ALARMS];
    cell_cmd_t   cmd;
    logic        cmd_en;
    logic        in_fire, out_fire;
    logic        full, has_free;
    logic [IW-1:0] free_id;
    logic        id_ok;
    logic [IW-1:0] scan_idx;
    logic [IW-1:0] free_id_reg;
    logic          full_reg;
    logic          id_ok_reg;
    logic [NUM_ALARMS-1:0] later_fire;
    logic        ovalid_reg;
    logic [1:0]  ost_reg;
    logic [2:0]  oid_reg;
    logic [31:0] orem_reg;
    logic        ofired_reg;
    logic [30:0] orel_reg;
    logic        odue_reg;
    logic        olast_reg;
    logic        tick_wait;
    logic        scan_end;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign scan_idx = scan_reg[IW-1:0];

    // Lowest free slot, for the add reply.
    always_comb
    begin
        has_free = 1'b0;
        free_id  = '0;
        for (int i = NUM_ALARMS - 1; i >= 0; i--)
            if (!rpt[i].valid)
            begin
                has_free = 1'b1;
                free_id  = IW'(i);
            end
    end
    assign full  = !has_free;
    assign id_ok = ({3'b0, id_reg} < 6'(NUM_ALARMS)) && rpt[id_reg[IW-1:0]].valid;

    // Command to the cells, applied at the end of FSM_MOD.
    always_comb
    begin
        cmd.tick   = (act_reg == ACT_TICK) && boundary_reg;
        cmd.add    = (act_reg == ACT_ADD) && start_reg >= 31'(ALARM_PERIOD);
        cmd.remove = (act_reg == ACT_REMOVE) && id_ok;
        cmd.query  = (act_reg == ACT_QUERY);
        cmd.id     = {3'b0, id_reg};
        cmd.start  = start_reg;
        cmd.rearm  = rearm_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:  if (in_fire) state_next = FSM_MOD;
            FSM_MOD:
                if (act_reg != ACT_TICK) state_next = FSM_REPLY;
                else if (mcnt_reg == 7'd0) state_next = FSM_SCAN;
            FSM_SCAN:  state_next = FSM_OUT;
            FSM_OUT:
                if (out_fire && out_ch.last) state_next = FSM_IDLE;
            FSM_REPLY: state_next = FSM_OUT;
            default:   state_next = FSM_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        in_ch.ready = (state_reg == FSM_IDLE);
        cmd_en      = (state_reg == FSM_MOD) && (act_reg != ACT_TICK || mcnt_reg == 7'd0);
    end

    // Restoring remainder of the tick count by the preemption period, one
    // bit of the count per cycle from the top bit down.
    assign div_step  = (state_reg == FSM_MOD) && (act_reg == ACT_TICK) && (mcnt_reg != 7'd0);
    assign bit_idx   = 6'(mcnt_reg - 7'd1);
    assign mrem_sh   = {mrem_reg, tick_reg[bit_idx]};
    assign mrem_next = (mrem_sh >= {1'b0, per_reg}) ? mrem_sh - {1'b0, per_reg} : mrem_sh;

    assign due = en_reg && per_reg != 32'd0 && mrem_reg == 32'd0;

    // Pending fires above the scan position, to mark the last result.
    always_comb
    begin
        for (int i = 0; i < NUM_ALARMS; i++)
            later_fire[i] = rpt[i].fire && ((IW+1)'(i) > scan_reg);
    end

    assign tick_wait = (state_reg == FSM_OUT) && (act_reg == ACT_TICK) && !olast_reg;
    assign scan_end  = (scan_reg == (IW+1)'(NUM_ALARMS - 1));

    // Datapath and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_IDLE;
            tick_reg   <= '0;
            phase_reg  <= '0;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
            scan_reg   <= '0;
            any_reg    <= 1'b0;
            mcnt_reg   <= '0;
            mrem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                act_reg   <= in_ch.action;
                start_reg <= in_ch.start_ticks;
                rearm_reg <= in_ch.rearm;
                id_reg    <= in_ch.target_id;
                mcnt_reg  <= 7'd64;
                mrem_reg  <= '0;
                if (in_ch.action == ACT_TICK)
                begin
                    tick_reg <= tick_reg + 64'd1;
                    boundary_reg <= (phase_reg == PW'(ALARM_PERIOD - 1));
                    phase_reg <= (phase_reg == PW'(ALARM_PERIOD - 1)) ? '0
                                 : phase_reg + PW'(1);
                end
            end
            // One remainder step per cycle.
            if (div_step)
            begin
                mcnt_reg <= mcnt_reg - 7'd1;
                mrem_reg <= mrem_next[31:0];
            end
            if (state_reg == FSM_SCAN)
            begin
                scan_reg <= '0;
                any_reg  <= 1'b0;
            end
            // Result register.
            if (out_fire)
                ovalid_reg <= 1'b0;
            if (state_reg == FSM_REPLY)
            begin
                ovalid_reg <= 1'b1;
                olast_reg  <= 1'b1;
                ofired_reg <= 1'b0;
                orel_reg   <= '0;
                odue_reg   <= 1'b0;
                orem_reg   <= '0;
                oid_reg    <= id_reg;
                ost_reg    <= ST_OK;
                unique case (act_reg)
                    ACT_ADD:
                        if (start_reg < 31'(ALARM_PERIOD))
                        begin
                            ost_reg <= ST_LOW; oid_reg <= '0;
                        end
                        else
                            oid_reg <= 3'(free_id_reg);
                    ACT_REMOVE:
                        if (!id_ok_reg) ost_reg <= ST_NOTFND;
                    ACT_QUERY:
                        if (!id_ok_reg) ost_reg <= ST_NOTFND;
                        else orem_reg <= rpt[id_reg[IW-1:0]].remaining;
                    default: ;
                endcase
                if (act_reg == ACT_ADD && start_reg >= 31'(ALARM_PERIOD) && full_reg)
                begin
                    ost_reg <= ST_FULL; oid_reg <= '0;
                end
            end
            // Scan of the cells, one per cycle, when the result register is free.
            if (tick_wait && (!ovalid_reg || out_fire))
            begin
                scan_reg <= scan_reg + (IW+1)'(1);
                if (rpt[scan_idx].fire || (scan_end && !any_reg))
                begin
                    ovalid_reg <= 1'b1;
                    any_reg    <= 1'b1;
                    ost_reg    <= ST_OK;
                    oid_reg    <= rpt[scan_idx].fire ? 3'(scan_idx) : 3'd0;
                    orem_reg   <= '0;
                    ofired_reg <= rpt[scan_idx].fire;
                    orel_reg   <= rpt[scan_idx].fire ? rpt[scan_idx].reload : '0;
                    odue_reg   <= due;
                    olast_reg  <= scan_end || !(|later_fire);
                end
            end
            if (state_reg == FSM_SCAN)
                olast_reg <= 1'b0;
        end
    end

    // Add/remove decisions taken before the cells update.
    always_ff @(posedge clk)
    begin
        if (cmd_en)
        begin
            free_id_reg <= free_id;
            full_reg    <= full;
            id_ok_reg   <= id_ok;
        end
    end

    pat_chain #(.NUM_ALARMS(NUM_ALARMS)) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_en (cmd_en),
        .cmd    (cmd),
        .rpt    (rpt)
    );

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.status       = ost_reg;
    assign out_ch.result_id    = oid_reg;
    assign out_ch.remaining    = orem_reg;
    assign out_ch.fired        = ofired_reg;
    assign out_ch.reload_ticks = orel_reg;
    assign out_ch.tick_now     = tick_reg;
    assign out_ch.preempt_due  = odue_reg;
    assign out_ch.last         = olast_reg;

    `PAT_ASSERT_IMPL(a_busy_noready, state_reg != FSM_IDLE, !in_ch.ready)
    `PAT_ASSERT_NEXT(a_last_idle, out_fire && out_ch.last, state_reg == FSM_IDLE)
    `PAT_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
`default_nettype wire

// ===== bench/tb_periodic_alarm_table_top.sv =====
// ----------------------------------------------------------------------------
// Alarm table testbench
// Drives ticks, adds, removes and queries into the alarm table, predicts every
// result from a behavioural copy of the slot table and compares every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_periodic_alarm_table_top;
    import pat_pkg::*;

    localparam int NSLOT = 8;
    localparam int APER  = 5;

    typedef struct packed {
        action_t     action;
        logic [30:0] start_ticks;
        logic        rearm;
        logic [2:0]  target_id;
    } cmd_item_t;

    typedef struct packed {
        status_t            status;
        logic [2:0]         result_id;
        logic signed [31:0] remaining;
        logic               fired;
        logic [30:0]        reload_ticks;
        logic [63:0]        tick_now;
        logic               preempt_due;
        logic               last;
    } alarm_rpt_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    pat_in_if  in_ch ();
    pat_out_if out_ch ();

    periodic_alarm_table_top dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow of the block's state and registers.
    logic               sh_enable;
    logic [31:0]        sh_period;
    logic [63:0]        sh_ticks;
    int                 sh_phase;
    logic               sh_valid [NSLOT];
    logic signed [31:0] sh_rem [NSLOT];
    logic [30:0]        sh_reload [NSLOT];
    logic               sh_rearm [NSLOT];

    cmd_item_t  pending_cmds [$];
    alarm_rpt_t expected_rpts [$];
    int         mismatches = 0;
    int         rpts_seen = 0;
    int         fires_seen = 0;
    int         phase_no = -1;
    bit         calm = 0;
    bit         hold_rx = 0;
    bit         in_taken = 0;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    // Works out the results of one item and advances the shadow table.
    task automatic predict_alarms(input cmd_item_t c);
        alarm_rpt_t r;
        logic       due;
        int         n;
        int         k;
        n = 0;
        r = '0;
        if (c.action == ACT_TICK) begin
            sh_ticks = sh_ticks + 1;
            sh_phase = sh_phase + 1;
            due = sh_enable && sh_period != 0 && (sh_ticks % sh_period) == 0;
            if (sh_phase >= APER) begin
                sh_phase = 0;
                for (k = 0; k < NSLOT; k++) begin
                    if (sh_valid[k]) begin
                        if (sh_rem[k] > 0)
                            sh_rem[k] = sh_rem[k] - DECREMENT;
                        if (sh_rem[k] <= 0) begin
                            r = '0;
                            r.result_id = k[2:0];
                            r.fired = 1'b1;
                            r.reload_ticks = sh_reload[k];
                            r.tick_now = sh_ticks;
                            r.preempt_due = due;
                            expected_rpts.push_back(r);
                            n++;
                            if (sh_rearm[k])
                                sh_rem[k] = {1'b0, sh_reload[k]};
                        end
                    end
                end
            end
            if (n == 0) begin
                r = '0;
                r.tick_now = sh_ticks;
                r.preempt_due = due;
                r.last = 1'b1;
                expected_rpts.push_back(r);
            end else begin
                expected_rpts[$].last = 1'b1;
            end
        end else begin
            r.tick_now = sh_ticks;
            r.last = 1'b1;
            if (c.action == ACT_ADD) begin
                k = 0;
                while (k < NSLOT && sh_valid[k])
                    k++;
                if (c.start_ticks < APER)
                    r.status = ST_LOW;
                else if (k >= NSLOT)
                    r.status = ST_FULL;
                else begin
                    sh_valid[k] = 1'b1;
                    sh_rem[k] = {1'b0, c.start_ticks};
                    sh_reload[k] = c.start_ticks;
                    sh_rearm[k] = c.rearm;
                    r.result_id = k[2:0];
                end
            end else begin
                r.result_id = c.target_id;
                if (!sh_valid[c.target_id])
                    r.status = ST_NOTFND;
                else if (c.action == ACT_REMOVE)
                    sh_valid[c.target_id] = 1'b0;
                else
                    r.remaining = sh_rem[c.target_id];
            end
            expected_rpts.push_back(r);
        end
    endtask

    // Sender: offers items from the pending queue with random gaps, holding
    // an offered item until it has been taken.
    always @(negedge clk) begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid && !in_taken)
            in_ch.valid <= 1'b1;
        else begin
            in_taken = 1'b0;
            if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
                in_ch.valid       <= 1'b1;
                in_ch.action      <= pending_cmds[0].action;
                in_ch.start_ticks <= pending_cmds[0].start_ticks;
                in_ch.rearm       <= pending_cmds[0].rearm;
                in_ch.target_id   <= pending_cmds[0].target_id;
            end else
                in_ch.valid <= 1'b0;
        end
    end

    // Acceptance: predict at the edge where the item is taken.
    always @(posedge clk) begin
        cmd_item_t c;
        if (rst_n && in_ch.valid && in_ch.ready) begin
            c = pending_cmds.pop_front();
            in_taken = 1'b1;
            predict_alarms(c);
        end
    end

    // Receiver stalls.
    always @(negedge clk) begin
        if (!rst_n || hold_rx)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= calm || $urandom_range(99) >= 19;
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    initial begin
        wait (phase_no == 1);
        hold_rx = 1;
        repeat (400) @(posedge clk);
        hold_rx = 0;
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge clk) begin
        alarm_rpt_t got;
        alarm_rpt_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.status       = status_t'(out_ch.status);
            got.result_id    = out_ch.result_id;
            got.remaining    = out_ch.remaining;
            got.fired        = out_ch.fired;
            got.reload_ticks = out_ch.reload_ticks;
            got.tick_now     = out_ch.tick_now;
            got.preempt_due  = out_ch.preempt_due;
            got.last         = out_ch.last;
            rpts_seen++;
            if (got.fired)
                fires_seen++;
            if (expected_rpts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end else begin
                want = expected_rpts.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Register write over APB while the block is idle.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == 3'd0)
            sh_enable = data[0];
        else if (addr == 3'd4)
            sh_period = data;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits for the queues to drain and then for the tick pipeline to settle.
    task automatic drain();
        while (pending_cmds.size() != 0 || expected_rpts.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic cmd_item_t mk(action_t a, logic [30:0] s, logic rr, logic [2:0] id);
        cmd_item_t c;
        c.action = a;
        c.start_ticks = s;
        c.rearm = rr;
        c.target_id = id;
        return c;
    endfunction

    // Random item; adds use short counts mostly so that slots fire often.
    function automatic cmd_item_t rand_cmd();
        cmd_item_t c;
        int        p;
        c.start_ticks = 31'($urandom);
        c.rearm = 1'($urandom_range(1));
        c.target_id = 3'($urandom_range(7));
        p = $urandom_range(99);
        if (p < 55)
            c.action = ACT_TICK;
        else if (p < 75) begin
            c.action = ACT_ADD;
            if ($urandom_range(9) < 7)
                c.start_ticks = 31'($urandom_range(40));
            else if ($urandom_range(1) == 0)
                c.start_ticks = 31'($urandom_range(4));
        end else if (p < 87)
            c.action = ACT_REMOVE;
        else
            c.action = ACT_QUERY;
        return c;
    endfunction

    initial begin
        int k;
        int phase;
        in_ch.valid = 0;
        in_ch.action = ACT_TICK;
        in_ch.start_ticks = 0;
        in_ch.rearm = 0;
        in_ch.target_id = 0;
        out_ch.ready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        sh_enable = 0;
        sh_period = 0;
        sh_ticks = 0;
        sh_phase = 0;
        for (k = 0; k < NSLOT; k++) begin
            sh_valid[k] = 0;
            sh_rem[k] = 0;
            sh_reload[k] = 0;
            sh_rearm[k] = 0;
        end
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: field extremes, every status, full table and repeated fires.
        write_reg(3'd0, 32'd1);
        write_reg(3'd4, 32'd3);
        pending_cmds.push_back(mk(ACT_ADD, 31'd4, 1'b0, 3'd0));
        pending_cmds.push_back(mk(ACT_ADD, 31'd0, 1'b1, 3'd7));
        pending_cmds.push_back(mk(ACT_ADD, 31'd5, 1'b0, 3'd0));
        pending_cmds.push_back(mk(ACT_ADD, 31'h7fffffff, 1'b1, 3'd7));
        pending_cmds.push_back(mk(ACT_ADD, 31'd7, 1'b1, 3'd0));
        for (k = 0; k < 5; k++)
            pending_cmds.push_back(mk(ACT_ADD, 31'(6 + k), k[0], 3'd0));
        pending_cmds.push_back(mk(ACT_ADD, 31'd9, 1'b0, 3'd0));
        pending_cmds.push_back(mk(ACT_QUERY, 31'h7fffffff, 1'b1, 3'd1));
        pending_cmds.push_back(mk(ACT_REMOVE, 31'd0, 1'b0, 3'd7));
        pending_cmds.push_back(mk(ACT_QUERY, 31'd0, 1'b0, 3'd7));
        pending_cmds.push_back(mk(ACT_REMOVE, 31'd0, 1'b0, 3'd7));
        for (k = 0; k < 10; k++)
            pending_cmds.push_back(mk(ACT_TICK, 31'h7fffffff, 1'b1, 3'd7));
        pending_cmds.push_back(mk(ACT_QUERY, 31'd0, 1'b0, 3'd0));
        drain();

        // Random phases with varied preemption settings, the extremes among them.
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(3'd0, 32'd0); write_reg(3'd4, 32'd2); end
                1: begin write_reg(3'd0, 32'd1); write_reg(3'd4, 32'hffffffff); end
                2: begin write_reg(3'd0, 32'd1); write_reg(3'd4, 32'd0); end
                3: begin write_reg(3'd0, 32'hfffffffe); write_reg(3'd4, 32'd1); end
                default: begin write_reg(3'd0, 32'd1); write_reg(3'd4, $urandom_range(1, 9)); end
            endcase
            calm = (phase == 2);
            for (k = 0; k < 86; k++)
                pending_cmds.push_back(rand_cmd());
            phase_no = phase;
            drain();
        end

        $display("Covered %0d ticks with %0d results, %0d of them alarm fires,",
                 sh_ticks, rpts_seen, fires_seen);
        $display("over six preemption settings including a long receiver stall.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pat_pkg.sv
hw/rtl/pat_if.sv
hw/rtl/pat_cell.sv
hw/rtl/pat_chain.sv
hw/rtl/periodic_alarm_table_top.sv
bench/tb_periodic_alarm_table_top.sv
